// ===== rtl/tvbb_pkg.sv =====
// ----------------------------------------------------------------------------
// tvbb_pkg
// Types and constants shared by the transformed vertex bounding box block.
// ----------------------------------------------------------------------------
`default_nettype none

package tvbb_pkg;

    localparam int AXES    = 3;
    localparam int COLS    = 4;
    localparam int COORD_W = 32;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = 2 * COORD_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int SHR_W   = SUM_W - FRAC_W;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic signed [SHR_W-1:0]   shr_t;

    localparam logic ACTION_LOAD   = 1'b0;
    localparam logic ACTION_VERTEX = 1'b1;

    localparam logic [1:0] TRANS_COL = 2'd3;

    localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
    localparam coord_t COORD_MIN = 32'sh8000_0000;

endpackage

`default_nettype wire

// ===== rtl/transformed_vertex_bounding_box_top.sv =====
// ----------------------------------------------------------------------------
// transformed_vertex_bounding_box_top
// Affine transform of streamed vertices with a running axis-aligned box.
// ----------------------------------------------------------------------------
// Takes one request per cycle while in_stall is low. A coefficient load
// (action 0) writes the 3x4 matrix as it leaves the input register, so it
// applies to every vertex accepted after it. A vertex (action 1) passes the
// input register, a stage of nine 32x32 multipliers, a stage summing the
// products of each row, and a stage that drops the 16 fraction bits (floor),
// adds the translation and saturates to 32 bits; the running bounds update as
// the point leaves that stage. A vertex marked last loads the result register
// with the six bounds as it leaves that stage; the next vertex starts a new
// box. The pipeline only backs up when a box is held in the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module transformed_vertex_bounding_box_top
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   in_valid,
    output      logic                   in_stall,
    input  wire logic                   action,
    input  wire logic [3:0]             coef_index,
    input  wire tvbb_pkg::coord_t       coef_value,
    input  wire tvbb_pkg::coord_t       vertex_x,
    input  wire tvbb_pkg::coord_t       vertex_y,
    input  wire tvbb_pkg::coord_t       vertex_z,
    input  wire logic                   last_vertex,

    output      logic                   out_valid,
    input  wire logic                   out_stall,
    output      tvbb_pkg::coord_t       min_x,
    output      tvbb_pkg::coord_t       min_y,
    output      tvbb_pkg::coord_t       min_z,
    output      tvbb_pkg::coord_t       max_x,
    output      tvbb_pkg::coord_t       max_y,
    output      tvbb_pkg::coord_t       max_z
);

    // matrix store, undefined until written
    tvbb_pkg::coord_t coef_reg [tvbb_pkg::AXES][tvbb_pkg::COLS];

    // input register
    logic               s0_valid_reg;
    logic               s0_action_reg;
    logic [3:0]         s0_index_reg;
    tvbb_pkg::coord_t   s0_value_reg;
    tvbb_pkg::coord_t   s0_vtx_reg [tvbb_pkg::AXES];
    logic               s0_last_reg;

    // product stage
    logic               s1_valid_reg;
    logic               s1_last_reg;
    tvbb_pkg::prod_t    s1_prod_reg [tvbb_pkg::AXES][tvbb_pkg::AXES];
    tvbb_pkg::coord_t   s1_trans_reg [tvbb_pkg::AXES];
    tvbb_pkg::prod_t    s1_prod_next [tvbb_pkg::AXES][tvbb_pkg::AXES];

    // sum stage
    logic               s2_valid_reg;
    logic               s2_last_reg;
    tvbb_pkg::sum_t     s2_sum_reg [tvbb_pkg::AXES];
    tvbb_pkg::coord_t   s2_trans_reg [tvbb_pkg::AXES];
    tvbb_pkg::sum_t     s2_sum_next [tvbb_pkg::AXES];

    // point stage
    logic               s3_valid_reg;
    logic               s3_last_reg;
    tvbb_pkg::coord_t   s3_pt_reg [tvbb_pkg::AXES];
    tvbb_pkg::coord_t   s3_pt_next [tvbb_pkg::AXES];

    // running bounds and result
    logic               first_reg;
    tvbb_pkg::coord_t   min_reg [tvbb_pkg::AXES];
    tvbb_pkg::coord_t   max_reg [tvbb_pkg::AXES];
    tvbb_pkg::coord_t   min_next [tvbb_pkg::AXES];
    tvbb_pkg::coord_t   max_next [tvbb_pkg::AXES];
    logic               out_valid_reg;
    tvbb_pkg::coord_t   out_min_reg [tvbb_pkg::AXES];
    tvbb_pkg::coord_t   out_max_reg [tvbb_pkg::AXES];

    logic s0_adv, s1_adv, s2_adv, s3_adv, out_free, in_take, coef_we;

    assign out_free = !out_valid_reg || !out_stall;
    assign s3_adv   = s3_valid_reg && (!s3_last_reg || out_free);
    assign s2_adv   = s2_valid_reg && (!s3_valid_reg || s3_adv);
    assign s1_adv   = s1_valid_reg && (!s2_valid_reg || s2_adv);
    assign s0_adv   = s0_valid_reg
                      && (s0_action_reg == tvbb_pkg::ACTION_LOAD || !s1_valid_reg || s1_adv);
    assign in_stall = s0_valid_reg && !s0_adv;
    assign in_take  = in_valid && !in_stall;
    assign coef_we  = s0_adv && s0_action_reg == tvbb_pkg::ACTION_LOAD
                      && s0_index_reg[3:2] != 2'd3;

    always_comb
    begin
        for (int a = 0; a < tvbb_pkg::AXES; a++)
        begin
            for (int c = 0; c < tvbb_pkg::AXES; c++)
            begin
                s1_prod_next[a][c] = coef_reg[a][c] * s0_vtx_reg[c];
            end
            s2_sum_next[a] = tvbb_pkg::SUM_W'(s1_prod_reg[a][0])
                             + tvbb_pkg::SUM_W'(s1_prod_reg[a][1])
                             + tvbb_pkg::SUM_W'(s1_prod_reg[a][2]);
        end
    end

    always_comb
    begin
        tvbb_pkg::shr_t r;
        for (int a = 0; a < tvbb_pkg::AXES; a++)
        begin
            r = tvbb_pkg::shr_t'(s2_sum_reg[a] >>> tvbb_pkg::FRAC_W)
                + tvbb_pkg::SHR_W'(s2_trans_reg[a]);
            if (r > tvbb_pkg::SHR_W'(tvbb_pkg::COORD_MAX))
                s3_pt_next[a] = tvbb_pkg::COORD_MAX;
            else if (r < tvbb_pkg::SHR_W'(tvbb_pkg::COORD_MIN))
                s3_pt_next[a] = tvbb_pkg::COORD_MIN;
            else
                s3_pt_next[a] = r[tvbb_pkg::COORD_W-1:0];
        end
    end

    always_comb
    begin
        for (int a = 0; a < tvbb_pkg::AXES; a++)
        begin
            if (first_reg || s3_pt_reg[a] < min_reg[a])
                min_next[a] = s3_pt_reg[a];
            else
                min_next[a] = min_reg[a];
            if (first_reg || s3_pt_reg[a] > max_reg[a])
                max_next[a] = s3_pt_reg[a];
            else
                max_next[a] = max_reg[a];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            first_reg     <= 1'b1;
            for (int a = 0; a < tvbb_pkg::AXES; a++)
            begin
                min_reg[a] <= '0;
                max_reg[a] <= '0;
            end
        end
        else
        begin
            if (in_take)
                s0_valid_reg <= 1'b1;
            else if (s0_adv)
                s0_valid_reg <= 1'b0;

            if (s0_adv && s0_action_reg == tvbb_pkg::ACTION_VERTEX)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                s2_valid_reg <= 1'b1;
            else if (s2_adv)
                s2_valid_reg <= 1'b0;

            if (s2_adv)
                s3_valid_reg <= 1'b1;
            else if (s3_adv)
                s3_valid_reg <= 1'b0;

            if (s3_adv && s3_last_reg)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (s3_adv)
            begin
                first_reg <= s3_last_reg;
                for (int a = 0; a < tvbb_pkg::AXES; a++)
                begin
                    min_reg[a] <= min_next[a];
                    max_reg[a] <= max_next[a];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s0_action_reg <= action;
            s0_index_reg  <= coef_index;
            s0_value_reg  <= coef_value;
            s0_vtx_reg[0] <= vertex_x;
            s0_vtx_reg[1] <= vertex_y;
            s0_vtx_reg[2] <= vertex_z;
            s0_last_reg   <= last_vertex;
        end

        if (coef_we)
            coef_reg[s0_index_reg[3:2]][s0_index_reg[1:0]] <= s0_value_reg;

        if (s0_adv && s0_action_reg == tvbb_pkg::ACTION_VERTEX)
        begin
            s1_last_reg <= s0_last_reg;
            for (int a = 0; a < tvbb_pkg::AXES; a++)
            begin
                s1_trans_reg[a] <= coef_reg[a][tvbb_pkg::TRANS_COL];
                for (int c = 0; c < tvbb_pkg::AXES; c++)
                begin
                    s1_prod_reg[a][c] <= s1_prod_next[a][c];
                end
            end
        end

        if (s1_adv)
        begin
            s2_last_reg <= s1_last_reg;
            for (int a = 0; a < tvbb_pkg::AXES; a++)
            begin
                s2_sum_reg[a]   <= s2_sum_next[a];
                s2_trans_reg[a] <= s1_trans_reg[a];
            end
        end

        if (s2_adv)
        begin
            s3_last_reg <= s2_last_reg;
            for (int a = 0; a < tvbb_pkg::AXES; a++)
            begin
                s3_pt_reg[a] <= s3_pt_next[a];
            end
        end

        if (s3_adv && s3_last_reg)
        begin
            for (int a = 0; a < tvbb_pkg::AXES; a++)
            begin
                out_min_reg[a] <= min_next[a];
                out_max_reg[a] <= max_next[a];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign min_x     = out_min_reg[0];
    assign min_y     = out_min_reg[1];
    assign min_z     = out_min_reg[2];
    assign max_x     = out_max_reg[0];
    assign max_y     = out_max_reg[1];
    assign max_z     = out_max_reg[2];

endmodule

`default_nettype wire

// ===== rtl/tvbb_checker.sv =====
// ----------------------------------------------------------------------------
// tvbb_checker
// Port-level checks on the result channel of the bounding box block.
// ----------------------------------------------------------------------------
`default_nettype none

module tvbb_checker
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             out_valid,
    input wire logic             out_stall,
    input wire tvbb_pkg::coord_t min_x,
    input wire tvbb_pkg::coord_t min_y,
    input wire tvbb_pkg::coord_t min_z,
    input wire tvbb_pkg::coord_t max_x,
    input wire tvbb_pkg::coord_t max_y,
    input wire tvbb_pkg::coord_t max_z
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result request dropped while stalled");

    a_hold_box: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(min_x) && $stable(max_x)
                                   && $stable(min_y) && $stable(max_y)
                                   && $stable(min_z) && $stable(max_z))
        else $error("stalled result changed");

    a_order_x: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> min_x <= max_x)
        else $error("x bounds out of order");

    a_order_yz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> min_y <= max_y && min_z <= max_z)
        else $error("y or z bounds out of order");

endmodule

bind transformed_vertex_bounding_box_top tvbb_checker u_tvbb_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .min_x     (min_x),
    .min_y     (min_y),
    .min_z     (min_z),
    .max_x     (max_x),
    .max_y     (max_y),
    .max_z     (max_z)
);

`default_nettype wire

// ===== test/tb_transformed_vertex_bounding_box_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_transformed_vertex_bounding_box_top
// Self-checking bench for the transformed vertex bounding box block.
// ----------------------------------------------------------------------------
// Coefficient loads and vertex requests are queued up front and fed by a
// clocked driver with random gaps. On every accepted vertex a local model
// applies the 3x4 Q16.16 affine transform (floor of the fraction, translation,
// 32-bit saturation), tracks the running box and queues the expected box when
// a vertex is marked last. A clocked monitor stalls the output at random, once
// for a long stretch, and compares every box field by field.
// ----------------------------------------------------------------------------

module tb_transformed_vertex_bounding_box_top;

    localparam int     COEF_SLOTS    = tvbb_pkg::AXES * tvbb_pkg::COLS;
    localparam int     TARGET_REQS   = 1650;
    localparam int     PRESSURE_AT   = 300;
    localparam int     HOLD_CYCLES   = 150;
    localparam int     DRAIN_CYCLES  = 16;
    localparam int     WATCHDOG_MAX  = 4000;
    localparam tvbb_pkg::coord_t UNIT = 32'sh0001_0000;

    typedef struct {
        logic             action;
        logic [3:0]       coef_index;
        tvbb_pkg::coord_t coef_value;
        tvbb_pkg::coord_t vx;
        tvbb_pkg::coord_t vy;
        tvbb_pkg::coord_t vz;
        logic             last;
        int unsigned      gap_after;
    } request_t;

    typedef struct packed {
        tvbb_pkg::coord_t min_x;
        tvbb_pkg::coord_t min_y;
        tvbb_pkg::coord_t min_z;
        tvbb_pkg::coord_t max_x;
        tvbb_pkg::coord_t max_y;
        tvbb_pkg::coord_t max_z;
    } box_t;

    logic             clk;
    logic             rst_n       = 1'b0;
    logic             in_valid    = 1'b0;
    logic             in_stall;
    logic             action      = tvbb_pkg::ACTION_LOAD;
    logic [3:0]       coef_index  = '0;
    tvbb_pkg::coord_t coef_value  = '0;
    tvbb_pkg::coord_t vertex_x    = '0;
    tvbb_pkg::coord_t vertex_y    = '0;
    tvbb_pkg::coord_t vertex_z    = '0;
    logic             last_vertex = 1'b0;
    logic             out_valid;
    logic             out_stall   = 1'b0;
    tvbb_pkg::coord_t min_x;
    tvbb_pkg::coord_t min_y;
    tvbb_pkg::coord_t min_z;
    tvbb_pkg::coord_t max_x;
    tvbb_pkg::coord_t max_y;
    tvbb_pkg::coord_t max_z;

    request_t    pending_reqs[$];
    request_t    shown_req;
    box_t        expected_boxes[$];

    tvbb_pkg::coord_t coef_tbl[COEF_SLOTS];
    tvbb_pkg::coord_t run_lo[tvbb_pkg::AXES];
    tvbb_pkg::coord_t run_hi[tvbb_pkg::AXES];
    logic        fresh_run;

    int          made_reqs;
    int          accepted_reqs;
    int          n_loads;
    int          n_vertices;
    int          n_boxes;
    int          sat_hits;
    int          errors;
    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned phase_left;
    int unsigned hold_left;
    logic        sink_eager;
    logic        hold_done;
    int unsigned idle_cycles;

    transformed_vertex_bounding_box_top dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .coef_index  (coef_index),
        .coef_value  (coef_value),
        .vertex_x    (vertex_x),
        .vertex_y    (vertex_y),
        .vertex_z    (vertex_z),
        .last_vertex (last_vertex),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .min_x       (min_x),
        .min_y       (min_y),
        .min_z       (min_z),
        .max_x       (max_x),
        .max_y       (max_y),
        .max_z       (max_z)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic tvbb_pkg::coord_t rand_fix();
        case ($urandom_range(0, 9))
            0:       return tvbb_pkg::COORD_MAX;
            1:       return tvbb_pkg::COORD_MIN;
            2:       return '0;
            3, 4, 5: return tvbb_pkg::coord_t'($urandom);
            default: return tvbb_pkg::coord_t'($urandom_range(0, 1 << 20))
                            - tvbb_pkg::coord_t'(1 << 19);
        endcase
    endfunction

    function automatic int unsigned pick_gap(input logic quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(25, 80);
    endfunction

    task automatic add_req(input logic act, input logic [3:0] idx,
                           input tvbb_pkg::coord_t val, input tvbb_pkg::coord_t x,
                           input tvbb_pkg::coord_t y, input tvbb_pkg::coord_t z,
                           input logic last, input logic quiet);
        request_t r;
        r.action     = act;
        r.coef_index = idx;
        r.coef_value = val;
        r.vx         = x;
        r.vy         = y;
        r.vz         = z;
        r.last       = last;
        r.gap_after  = pick_gap(quiet);
        pending_reqs.insert(pending_reqs.size(), r);
        if (act == tvbb_pkg::ACTION_VERTEX || idx < COEF_SLOTS)
            made_reqs++;
    endtask

    task automatic add_load(input int idx, input tvbb_pkg::coord_t val, input logic quiet);
        add_req(tvbb_pkg::ACTION_LOAD, 4'(idx), val, rand_fix(), rand_fix(), rand_fix(),
                1'($urandom), quiet);
    endtask

    task automatic add_vertex(input tvbb_pkg::coord_t x, input tvbb_pkg::coord_t y,
                              input tvbb_pkg::coord_t z, input logic last,
                              input logic quiet);
        add_req(tvbb_pkg::ACTION_VERTEX, 4'($urandom), tvbb_pkg::coord_t'($urandom),
                x, y, z, last, quiet);
    endtask

    task automatic build_directed();
        int i;
        // identity matrix; junk vertex fields must be ignored on loads
        for (i = 0; i < COEF_SLOTS; i++)
            add_load(i, (i % tvbb_pkg::COLS == i / tvbb_pkg::COLS)
                        ? UNIT : tvbb_pkg::coord_t'(0), 1'b0);
        // loads past the matrix are dropped
        add_load(15, tvbb_pkg::COORD_MIN, 1'b0);
        add_load(12, tvbb_pkg::COORD_MAX, 1'b0);
        // single-vertex box at the coordinate extremes
        add_vertex(tvbb_pkg::COORD_MAX, tvbb_pkg::COORD_MIN, -32'sd1, 1'b1, 1'b0);
        // saturation both ways, then a translation reload inside the run
        add_load(0, tvbb_pkg::COORD_MAX, 1'b0);
        add_vertex(tvbb_pkg::COORD_MAX, '0, '0, 1'b0, 1'b0);
        add_vertex(tvbb_pkg::COORD_MIN, '0, '0, 1'b0, 1'b1);
        add_load(tvbb_pkg::TRANS_COL, tvbb_pkg::COORD_MIN, 1'b1);
        add_vertex(32'sd1, 32'sd1, 32'sd1, 1'b1, 1'b0);
        // translation pushes past the top
        add_load(tvbb_pkg::COLS + tvbb_pkg::TRANS_COL, tvbb_pkg::COORD_MAX, 1'b0);
        add_vertex('0, UNIT, '0, 1'b1, 1'b0);
        // largest products of both signs
        add_load(2 * tvbb_pkg::COLS + 2, tvbb_pkg::COORD_MIN, 1'b0);
        add_vertex('0, '0, tvbb_pkg::COORD_MIN, 1'b1, 1'b0);
        add_vertex('0, '0, tvbb_pkg::COORD_MAX, 1'b1, 1'b0);
    endtask

    task automatic build_random();
        int   kind;
        int   nv;
        int   i;
        logic quiet;
        while (made_reqs < TARGET_REQS)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            kind  = $urandom_range(0, 9);
            if (kind < 8)
            begin
                for (i = $urandom_range(0, 3); i > 0; i--)
                    add_load($urandom_range(0, COEF_SLOTS - 1), rand_fix(), quiet);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: nv = $urandom_range(1, 6);
                    6, 7, 8:          nv = $urandom_range(7, 20);
                    default:          nv = $urandom_range(21, 60);
                endcase
                for (i = 0; i < nv; i++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        add_load($urandom_range(0, COEF_SLOTS - 1), rand_fix(), quiet);
                    add_vertex(rand_fix(), rand_fix(), rand_fix(), i == nv - 1, quiet);
                end
            end
            else if (kind == 8)
            begin
                add_load($urandom_range(0, 15), rand_fix(), quiet);
            end
            else
            begin
                // whole matrix within +-2.0 so most points stay unsaturated
                for (i = 0; i < COEF_SLOTS; i++)
                    add_load(i, tvbb_pkg::coord_t'($urandom_range(0, 1 << 18))
                                - tvbb_pkg::coord_t'(1 << 17), quiet);
            end
        end
    endtask

    function automatic tvbb_pkg::coord_t project_axis(input int row,
                                                      input tvbb_pkg::coord_t px,
                                                      input tvbb_pkg::coord_t py,
                                                      input tvbb_pkg::coord_t pz);
        tvbb_pkg::sum_t c0;
        tvbb_pkg::sum_t c1;
        tvbb_pkg::sum_t c2;
        tvbb_pkg::sum_t tr;
        tvbb_pkg::sum_t ex;
        tvbb_pkg::sum_t ey;
        tvbb_pkg::sum_t ez;
        tvbb_pkg::sum_t pt;
        c0 = coef_tbl[tvbb_pkg::COLS * row];
        c1 = coef_tbl[tvbb_pkg::COLS * row + 1];
        c2 = coef_tbl[tvbb_pkg::COLS * row + 2];
        tr = coef_tbl[tvbb_pkg::COLS * row + tvbb_pkg::TRANS_COL];
        ex = px;
        ey = py;
        ez = pz;
        pt = ((c0 * ex + c1 * ey + c2 * ez) >>> tvbb_pkg::FRAC_W) + tr;
        if (pt > tvbb_pkg::sum_t'(tvbb_pkg::COORD_MAX))
        begin
            sat_hits++;
            return tvbb_pkg::COORD_MAX;
        end
        if (pt < tvbb_pkg::sum_t'(tvbb_pkg::COORD_MIN))
        begin
            sat_hits++;
            return tvbb_pkg::COORD_MIN;
        end
        return tvbb_pkg::coord_t'(pt);
    endfunction

    task automatic absorb_request(input request_t r);
        tvbb_pkg::coord_t pt[tvbb_pkg::AXES];
        box_t   b;
        int     a;
        if (r.action == tvbb_pkg::ACTION_LOAD)
        begin
            if (r.coef_index < COEF_SLOTS)
                coef_tbl[r.coef_index] = r.coef_value;
            n_loads++;
            return;
        end
        n_vertices++;
        pt[0] = project_axis(0, r.vx, r.vy, r.vz);
        pt[1] = project_axis(1, r.vx, r.vy, r.vz);
        pt[2] = project_axis(2, r.vx, r.vy, r.vz);
        for (a = 0; a < tvbb_pkg::AXES; a++)
        begin
            if (fresh_run || pt[a] < run_lo[a])
                run_lo[a] = pt[a];
            if (fresh_run || pt[a] > run_hi[a])
                run_hi[a] = pt[a];
        end
        fresh_run = 1'b0;
        if (r.last)
        begin
            b.min_x = run_lo[0];
            b.min_y = run_lo[1];
            b.min_z = run_lo[2];
            b.max_x = run_hi[0];
            b.max_y = run_hi[1];
            b.max_z = run_hi[2];
            expected_boxes.insert(expected_boxes.size(), b);
            fresh_run = 1'b1;
        end
    endtask

    task automatic check_field(input string name, input tvbb_pkg::coord_t want,
                               input tvbb_pkg::coord_t got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            action      <= tvbb_pkg::ACTION_LOAD;
            coef_index  <= '0;
            coef_value  <= '0;
            vertex_x    <= '0;
            vertex_y    <= '0;
            vertex_z    <= '0;
            last_vertex <= 1'b0;
            gap_left    = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                absorb_request(shown_req);
                accepted_reqs++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    shown_req   = pending_reqs.pop_front();
                    action      <= shown_req.action;
                    coef_index  <= shown_req.coef_index;
                    coef_value  <= shown_req.coef_value;
                    vertex_x    <= shown_req.vx;
                    vertex_y    <= shown_req.vy;
                    vertex_z    <= shown_req.vz;
                    last_vertex <= shown_req.last;
                    in_valid    <= 1'b1;
                    gap_left    = shown_req.gap_after;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // box monitor and output stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
            phase_left = 0;
            hold_left  = 0;
            sink_eager = 1'b1;
            hold_done  = 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_boxes.size() == 0)
                begin
                    $display("%0t: unexpected box, expected none, got %h %h %h %h %h %h",
                             $time, min_x, min_y, min_z, max_x, max_y, max_z);
                    errors++;
                end
                else
                begin
                    box_t want;
                    want = expected_boxes.pop_front();
                    check_field("min_x", want.min_x, min_x);
                    check_field("min_y", want.min_y, min_y);
                    check_field("min_z", want.min_z, min_z);
                    check_field("max_x", want.max_x, max_x);
                    check_field("max_y", want.max_y, max_y);
                    check_field("max_z", want.max_z, max_z);
                    n_boxes++;
                end
            end
            if (!hold_done && accepted_reqs >= PRESSURE_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (phase_left == 0)
            begin
                sink_eager = ($urandom_range(0, 2) == 0);
                phase_left = $urandom_range(40, 300);
            end
            else
            begin
                phase_left--;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!sink_eager && $urandom_range(0, 99) < 40)
            begin
                case ($urandom_range(0, 19))
                    0:             stall_left = $urandom_range(19, 49);
                    1, 2, 3, 4, 5: stall_left = $urandom_range(2, 7);
                    default:       stall_left = $urandom_range(0, 1);
                endcase
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_MAX);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        made_reqs     = 0;
        accepted_reqs = 0;
        n_loads       = 0;
        n_vertices    = 0;
        n_boxes       = 0;
        sat_hits      = 0;
        errors        = 0;
        idle_cycles   = 0;
        fresh_run     = 1'b1;
        foreach (coef_tbl[i])
            coef_tbl[i] = '0;
        foreach (run_lo[i])
        begin
            run_lo[i] = '0;
            run_hi[i] = '0;
        end
        build_directed();
        build_random();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_reqs.size() > 0 || in_valid || expected_boxes.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_boxes.size() > 0)
        begin
            $display("%0t: %0d boxes never arrived", $time, expected_boxes.size());
            errors++;
        end
        $display("Covered %0d coefficient loads and %0d vertices, %0d boxes compared,",
                 n_loads, n_vertices, n_boxes);
        $display("%0d saturated axis values, one long output hold; %0d errors",
                 sat_hits, errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
